// ===== sv/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg
// shared constants for the lfu cache policy block
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int ENTRIES_DEF    = 16;
   localparam int COUNT_BITS_DEF = 16;
   localparam int KEY_BITS_DEF   = 32;
   localparam int DATA_BITS      = 32;
   localparam int CAP_BITS       = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

endpackage

// ===== sv/lfu_req_if.sv =====
// ----------------------------------------------------------------------------
// lfu_req_if
// request channel: operation, key and value with valid/ready
// ----------------------------------------------------------------------------
interface lfu_req_if;
   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic [lfu_pkg::DATA_BITS-1:0] key;
   logic [lfu_pkg::DATA_BITS-1:0] value;

   modport source (output valid, operation, key, value, input ready);
   modport sink (input valid, operation, key, value, output ready);
endinterface

// ===== sv/lfu_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lfu_rsp_if
// response channel: hit, read value and eviction report with valid/ready
// ----------------------------------------------------------------------------
interface lfu_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         hit;
   logic [lfu_pkg::DATA_BITS-1:0] read_value;
   logic                         evicted;
   logic [lfu_pkg::DATA_BITS-1:0] evicted_key;

   modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
   modport sink (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

// ===== sv/lfu_cache_policy_top.sv =====
// ----------------------------------------------------------------------------
// lfu_cache_policy_top
// key-value cache with lfu replacement and lru tie break
// ----------------------------------------------------------------------------
// One request is handled at a time. Entry state (key, value, use count,
// recency rank) sits in one synchronous memory with a registered read;
// valid bits are flip-flops cleared at reset. A request walks the memory
// once to find the key and the lfu/lru victim, decides in S_DECIDE, then
// walks it again to write back ranks, counts and the new entry, and
// S_RESP sets the response valid. The response sits in an output
// register; the next request is taken once it has been transferred or
// together with that transfer. Capacity is written through csr_ and
// must only change while the cache is empty and idle.
// ----------------------------------------------------------------------------
module lfu_cache_policy_top #(
   parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
   parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
   parameter int KEY_BITS   = lfu_pkg::KEY_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [lfu_pkg::CAP_BITS-1:0] csr_write_data,
   lfu_req_if.sink                     req,
   lfu_rsp_if.source                   rsp
);

   localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS = $clog2(ENTRIES + 1);
   localparam int OCC_BITS = CNT_BITS;
   localparam int RANK_BITS = IDX_BITS;
   localparam int DW = lfu_pkg::DATA_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [DW-1:0]         value;
      logic [COUNT_BITS-1:0] count;
      logic [RANK_BITS-1:0]  rank;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_WRITE, S_RESP
   } state_type;

   // entry memory, one write and one read port, registered read
   entry_type mem [ENTRIES];
   entry_type rd_data_ff;
   logic      mem_we;
   logic [IDX_BITS-1:0] mem_waddr, mem_raddr;
   entry_type mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[mem_raddr];
   end

   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   logic [OCC_BITS-1:0] occ_ff;
   logic [lfu_pkg::CAP_BITS-1:0] cap_ff;

   state_type state_ff;
   logic [CNT_BITS-1:0] cnt_ff;        // address issued
   logic [IDX_BITS-1:0] ridx_ff;       // index of data in rd_data_ff
   logic                rvld_ff;       // rd_data_ff holds a scanned entry
   logic                op_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [DW-1:0]       val_ff;

   logic                found_ff;
   logic [IDX_BITS-1:0] fidx_ff;
   entry_type           fent_ff;
   logic                vfound_ff;
   logic [IDX_BITS-1:0] vidx_ff;
   entry_type           vent_ff;
   logic                free_ff;
   logic [IDX_BITS-1:0] free_idx_ff;

   // plan made in decide state
   logic                do_touch_ff, do_evict_ff, do_insert_ff;
   logic [IDX_BITS-1:0] tgt_ff;        // touched or inserted slot
   logic [RANK_BITS-1:0] old_rank_ff;
   logic [RANK_BITS-1:0] vrank_ff;

   logic                rsp_valid_ff, hit_ff, ev_ff;
   logic [DW-1:0]       rval_ff, evkey_ff;

   logic [KEY_BITS-1:0] req_key;
   assign req_key = KEY_BITS'(req.key);

   logic [lfu_pkg::CAP_BITS-1:0] cap_eff;
   assign cap_eff = (32'(cap_ff) > ENTRIES) ? lfu_pkg::CAP_BITS'(ENTRIES) : cap_ff;

   logic req_take;
   assign req.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign req_take  = req.valid && req.ready;

   // valid bits after the write pass: victim cleared, new entry set
   always_comb begin
      valid_in = valid_ff;
      if (do_evict_ff) valid_in[vidx_ff] = 1'b0;
      if (do_insert_ff) valid_in[tgt_ff] = 1'b1;
   end

   // write-pass read data: slot index ridx_ff is being written this cycle
   entry_type wr_ent;
   logic      wr_en;
   always_comb begin
      wr_ent = rd_data_ff;
      wr_en  = 1'b0;
      if (do_touch_ff) begin
         if (ridx_ff == tgt_ff) begin
            wr_ent.rank = '0;
            if (wr_ent.count != COUNT_MAX) wr_ent.count = wr_ent.count + 1'b1;
            if (op_ff == lfu_pkg::OP_PUT) wr_ent.value = val_ff;
            wr_en = 1'b1;
         end else if (valid_ff[ridx_ff] && rd_data_ff.rank < old_rank_ff) begin
            wr_ent.rank = rd_data_ff.rank + 1'b1;
            wr_en = 1'b1;
         end
      end else begin
         if (do_insert_ff && ridx_ff == tgt_ff) begin
            wr_ent.key   = key_ff;
            wr_ent.value = val_ff;
            wr_ent.count = COUNT_BITS'(1);
            wr_ent.rank  = '0;
            wr_en = 1'b1;
         end else if (valid_ff[ridx_ff] && !(do_evict_ff && ridx_ff == vidx_ff)) begin
            // close gap left by victim, then shift for the new entry
            if (do_evict_ff && rd_data_ff.rank > vrank_ff)
               wr_ent.rank = wr_ent.rank - 1'b1;
            if (do_insert_ff) wr_ent.rank = wr_ent.rank + 1'b1;
            wr_en = do_evict_ff || do_insert_ff;
         end
      end
   end

   always_comb begin
      mem_raddr = cnt_ff[IDX_BITS-1:0];
      mem_we    = (state_ff == S_WRITE) && rvld_ff && wr_en;
      mem_waddr = ridx_ff;
      mem_wdata = wr_ent;
   end

   // scan compare on the entry just read
   logic sc_valid, sc_match, sc_better;
   always_comb begin
      sc_valid  = rvld_ff && valid_ff[ridx_ff];
      sc_match  = sc_valid && rd_data_ff.key == key_ff;
      sc_better = sc_valid && (!vfound_ff || rd_data_ff.count < vent_ff.count ||
                  (rd_data_ff.count == vent_ff.count && rd_data_ff.rank > vent_ff.rank));
   end

   logic scan_last;
   assign scan_last = (cnt_ff == CNT_BITS'(ENTRIES));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         occ_ff       <= '0;
         cap_ff       <= lfu_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
         rvld_ff      <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (csr_write_enable) cap_ff <= csr_write_data;
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         ridx_ff <= cnt_ff[IDX_BITS-1:0];
         case (state_ff)
            S_IDLE: begin
               rvld_ff <= 1'b0;
               if (req_take) begin
                  op_ff     <= req.operation;
                  key_ff    <= req_key;
                  val_ff    <= req.value;
                  found_ff  <= 1'b0;
                  vfound_ff <= 1'b0;
                  free_ff   <= 1'b0;
                  cnt_ff    <= '0;
                  state_ff  <= S_SCAN;
               end
            end
            S_SCAN: begin
               rvld_ff <= !scan_last;
               if (!scan_last) cnt_ff <= cnt_ff + 1'b1;
               if (sc_match && !found_ff) begin
                  found_ff <= 1'b1;
                  fidx_ff  <= ridx_ff;
                  fent_ff  <= rd_data_ff;
               end
               if (sc_better) begin
                  vfound_ff <= 1'b1;
                  vidx_ff   <= ridx_ff;
                  vent_ff   <= rd_data_ff;
               end
               if (rvld_ff && !valid_ff[ridx_ff] && !free_ff) begin
                  free_ff     <= 1'b1;
                  free_idx_ff <= ridx_ff;
               end
               if (scan_last && !rvld_ff) state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               logic full, ev, ins;
               logic [IDX_BITS-1:0] fslot;
               full  = 32'(occ_ff) >= 32'(cap_eff);
               ev    = (op_ff == lfu_pkg::OP_PUT) && cap_eff != '0 && !found_ff &&
                       full && vfound_ff;
               // lowest free slot after a possible eviction
               fslot = free_idx_ff;
               if (ev && (!free_ff || vidx_ff < free_idx_ff)) fslot = vidx_ff;
               ins   = (op_ff == lfu_pkg::OP_PUT) && cap_eff != '0 && !found_ff &&
                       (free_ff || ev);
               do_touch_ff  <= found_ff && (op_ff == lfu_pkg::OP_GET || cap_eff != '0);
               do_evict_ff  <= ev;
               do_insert_ff <= ins;
               tgt_ff       <= found_ff ? fidx_ff : fslot;
               old_rank_ff  <= fent_ff.rank;
               vrank_ff     <= vent_ff.rank;
               hit_ff   <= found_ff && (op_ff == lfu_pkg::OP_GET || cap_eff != '0);
               rval_ff  <= (found_ff && op_ff == lfu_pkg::OP_GET) ? fent_ff.value : '0;
               ev_ff    <= ev;
               evkey_ff <= ev ? DW'(vent_ff.key) : '0;
               cnt_ff   <= '0;
               rvld_ff  <= 1'b0;
               state_ff <= S_WRITE;
            end
            S_WRITE: begin
               rvld_ff <= !scan_last;
               if (!scan_last) cnt_ff <= cnt_ff + 1'b1;
               if (scan_last && !rvld_ff) begin
                  valid_ff <= valid_in;
                  if (do_evict_ff && !do_insert_ff) occ_ff <= occ_ff - 1'b1;
                  if (do_insert_ff && !do_evict_ff) occ_ff <= occ_ff + 1'b1;
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.hit         = hit_ff;
   assign rsp.read_value  = rval_ff;
   assign rsp.evicted     = ev_ff;
   assign rsp.evicted_key = evkey_ff;

endmodule

// ===== sv/lfu_cache_policy_chk.sv =====
// ----------------------------------------------------------------------------
// lfu_cache_policy_chk
// port-level checks on the lfu cache policy block
// ----------------------------------------------------------------------------
module lfu_cache_policy_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic [31:0] rsp_read_value,
   input logic        rsp_evicted,
   input logic [31:0] rsp_evicted_key
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_evicted_key))
      else $error("response dropped or changed while stalled");

   a_no_evict_on_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_evicted))
      else $error("hit and eviction in one response");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_read_value == 32'd0)
      else $error("miss returned data");

   a_evkey_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted |-> rsp_evicted_key == 32'd0)
      else $error("evicted key without eviction");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken during processing");

endmodule

bind lfu_cache_policy_top lfu_cache_policy_chk u_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_hit         (rsp.hit),
   .rsp_read_value  (rsp.read_value),
   .rsp_evicted     (rsp.evicted),
   .rsp_evicted_key (rsp.evicted_key)
);

// ===== test/lfu_cache_policy_top_test.sv =====
// ----------------------------------------------------------------------------
// lfu_cache_policy_top_test
// self-checking test of the lfu cache with lru tie break
// ----------------------------------------------------------------------------
// A local copy of the cache state predicts hit, read value and eviction
// report for every request taken by the block. Directed tests cover
// capacity extremes, lfu victim choice and key extremes, random
// tests mix gets and puts over a small key pool so hits and evictions are
// frequent. The sender bursts and pauses, the receiver stalls on its own
// pattern, and one long receiver hold-off makes the block stall its input.
// ----------------------------------------------------------------------------
module lfu_cache_policy_top_test;

   localparam int NUM_SLOTS  = lfu_pkg::ENTRIES_DEF;
   localparam int COUNT_TOP  = (1 << lfu_pkg::COUNT_BITS_DEF) - 1;
   localparam int SETTLE_CYC = 80;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic        hit;
      logic [31:0] read_value;
      logic        evicted;
      logic [31:0] evicted_key;
   } lookup_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [lfu_pkg::CAP_BITS-1:0] csr_write_data = '0;

   lfu_req_if req ();
   lfu_rsp_if rsp ();

   lfu_cache_policy_top dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req(req.sink), .rsp(rsp.source)
   );

   // predicted cache contents
   logic [lfu_pkg::CAP_BITS-1:0] cap_reg;
   bit                  slot_valid [NUM_SLOTS];
   logic [31:0]         slot_key   [NUM_SLOTS];
   logic [31:0]         slot_value [NUM_SLOTS];
   int unsigned         slot_uses  [NUM_SLOTS];
   int unsigned         slot_rank  [NUM_SLOTS];
   int unsigned         fill_level;

   lookup_result_type pending_results[$];
   int      mismatch_count = 0;
   longint  cycle_count = 0;
   bit      hold_off = 1'b0;
   bit      stall_enable = 1'b1;
   logic [31:0] key_pool[8];

   initial begin
      forever #4 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // move slot to most recent and bump its saturating count
   function automatic void touch_slot(int s);
      for (int i = 0; i < NUM_SLOTS; i++)
         if (slot_valid[i] && i != s && slot_rank[i] < slot_rank[s])
            slot_rank[i]++;
      slot_rank[s] = 0;
      if (slot_uses[s] < COUNT_TOP) slot_uses[s]++;
   endfunction

   function automatic lookup_result_type predict_lookup(logic op, logic [31:0] key,
                                                        logic [31:0] value);
      lookup_result_type r;
      int found;
      int victim;
      int free_slot;
      int unsigned cap;
      r = '0;
      found = -1;
      victim = -1;
      free_slot = -1;
      cap = (cap_reg > NUM_SLOTS) ? NUM_SLOTS : cap_reg;
      for (int i = NUM_SLOTS - 1; i >= 0; i--)
         if (slot_valid[i] && slot_key[i] == key) found = i;
      if (op == lfu_pkg::OP_GET) begin
         if (found >= 0) begin
            r.hit = 1'b1;
            r.read_value = slot_value[found];
            touch_slot(found);
         end
         return r;
      end
      if (cap == 0) return r;
      if (found >= 0) begin
         r.hit = 1'b1;
         slot_value[found] = value;
         touch_slot(found);
         return r;
      end
      // full (or over capacity): drop lowest count, oldest among ties
      if (fill_level >= cap) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!slot_valid[i]) continue;
            if (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                (slot_uses[i] == slot_uses[victim] && slot_rank[i] > slot_rank[victim]))
               victim = i;
         end
         if (victim >= 0) begin
            for (int i = 0; i < NUM_SLOTS; i++)
               if (slot_valid[i] && i != victim && slot_rank[i] > slot_rank[victim])
                  slot_rank[i]--;
            slot_valid[victim] = 1'b0;
            if (fill_level > 0) fill_level--;
            r.evicted = 1'b1;
            r.evicted_key = slot_key[victim];
         end
      end
      for (int i = NUM_SLOTS - 1; i >= 0; i--)
         if (!slot_valid[i]) free_slot = i;
      if (free_slot < 0) return r;
      for (int i = 0; i < NUM_SLOTS; i++)
         if (slot_valid[i]) slot_rank[i]++;
      slot_valid[free_slot] = 1'b1;
      slot_key[free_slot] = key;
      slot_value[free_slot] = value;
      slot_uses[free_slot] = 1;
      slot_rank[free_slot] = 0;
      fill_level++;
      return r;
   endfunction

   // checker: compare each response transfer with the oldest prediction
   always @(posedge clock) begin
      lookup_result_type exp_r;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response transfer at cycle %0d", cycle_count);
         end else begin
            exp_r = pending_results[0];
            pending_results.delete(0);
            if (rsp.hit !== exp_r.hit || rsp.read_value !== exp_r.read_value ||
                rsp.evicted !== exp_r.evicted || rsp.evicted_key !== exp_r.evicted_key) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"response mismatch: exp hit %0b val %h ev %0b key %h,",
                            " got hit %0b val %h ev %0b key %h"},
                           exp_r.hit, exp_r.read_value, exp_r.evicted, exp_r.evicted_key,
                           rsp.hit, rsp.read_value, rsp.evicted, rsp.evicted_key);
            end
         end
      end
   end

   // receiver stall pattern, overridden by the long hold-off
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) rsp.ready <= 1'b0;
         else if (!stall_enable) rsp.ready <= 1'b1;
         else rsp.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // send one request, predicting its result on the transfer edge
   int burst_left = 0;
   task automatic send_request(logic op, logic [31:0] key, logic [31:0] value);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         repeat ($urandom_range(0, 40)) @(negedge clock);
      end
      burst_left--;
      req.valid = 1'b1;
      req.operation = op;
      req.key = key;
      req.value = value;
      do @(posedge clock); while (!req.ready);
      pending_results.push_back(predict_lookup(op, key, value));
      @(negedge clock);
      req.valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYC) @(negedge clock);
   endtask

   // capacity written only when idle; empty the cache by reset-free eviction
   // is not possible, so capacity changes happen while entries may remain
   task automatic write_capacity(logic [lfu_pkg::CAP_BITS-1:0] cap);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= cap;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cap_reg = cap;
   endtask

   function automatic logic [31:0] pick_key();
      if ($urandom_range(0, 9) == 0) return $urandom();
      return key_pool[$urandom_range(0, 7)];
   endfunction

   // key extremes, get miss, put/update, get hit
   task automatic test_key_extremes();
      send_request(lfu_pkg::OP_GET, 32'h0, 32'h0);
      send_request(lfu_pkg::OP_PUT, 32'h0, 32'hFFFF_FFFF);
      send_request(lfu_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0);
      send_request(lfu_pkg::OP_GET, 32'h0, 32'h1234_5678);
      send_request(lfu_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
      send_request(lfu_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0);
      send_request(lfu_pkg::OP_GET, 32'h5555_AAAA, 32'h0);
   endtask

   // small capacity: lfu victim choice
   task automatic test_tie_break();
      write_capacity(5'd2);
      send_request(lfu_pkg::OP_PUT, 32'h10, 32'h1);  // full: evicts
      send_request(lfu_pkg::OP_PUT, 32'h11, 32'h2);
      send_request(lfu_pkg::OP_GET, 32'h10, 32'h0);
      send_request(lfu_pkg::OP_PUT, 32'h12, 32'h3);  // lfu victim
      send_request(lfu_pkg::OP_PUT, 32'h13, 32'h4);  // lfu victim again
      send_request(lfu_pkg::OP_GET, 32'h12, 32'h0);
   endtask

   // capacity zero: puts do nothing, gets still look up
   task automatic test_capacity_zero();
      write_capacity(5'd0);
      send_request(lfu_pkg::OP_PUT, 32'h20, 32'h5);
      send_request(lfu_pkg::OP_GET, 32'h20, 32'h0);
      send_request(lfu_pkg::OP_GET, 32'h13, 32'h0);
      send_request(lfu_pkg::OP_PUT, 32'h13, 32'h6);
      write_capacity(5'd1);
      send_request(lfu_pkg::OP_PUT, 32'h21, 32'h7);
      send_request(lfu_pkg::OP_PUT, 32'h22, 32'h8);
      write_capacity(5'd31);  // above the slot count acts as full size
   endtask

   // long receiver hold-off while requests keep coming
   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(negedge clock);
            hold_off = 1'b0;
         end
         for (int n = 0; n < 8; n++)
            send_request(1'($urandom_range(0, 1)), pick_key(), $urandom());
      join
   endtask

   task automatic test_random(int count);
      for (int n = 0; n < count; n++) begin
         if (n % 60 == 0) stall_enable = (n % 120 != 0);
         send_request(1'($urandom_range(0, 1)), pick_key(), $urandom());
      end
      stall_enable = 1'b1;
   endtask

   task automatic test_random_capacities();
      logic [lfu_pkg::CAP_BITS-1:0] caps[6] = '{5'd16, 5'd3, 5'd1, 5'd8, 5'd17, 5'd16};
      foreach (caps[i]) begin
         write_capacity(caps[i]);
         test_random(80);
      end
   endtask

   initial begin
      req.valid = 1'b0;
      req.operation = lfu_pkg::OP_GET;
      req.key = '0;
      req.value = '0;
      cap_reg = lfu_pkg::CAP_RESET;
      fill_level = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_valid[i] = 1'b0;
         slot_key[i] = '0;
         slot_value[i] = '0;
         slot_uses[i] = 0;
         slot_rank[i] = 0;
      end
      // pool of more keys than small capacities hold, so evictions happen
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_key_extremes();
      test_tie_break();
      test_capacity_zero();
      test_backpressure();
      test_random_capacities();
      test_random(40);

      wait_drained();
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/lfu_pkg.sv
sv/lfu_req_if.sv
sv/lfu_rsp_if.sv
sv/lfu_cache_policy_top.sv
sv/lfu_cache_policy_chk.sv
test/lfu_cache_policy_top_test.sv
